### rtl/core/gla_pkg.sv
package gla_pkg;

  typedef enum logic [3:0] {
    S_IDLE  = 4'b0001,
    S_CALC  = 4'b0010,
    S_WRB   = 4'b0100,
    S_CLEAR = 4'b1000
  } state_t;

  localparam int unsigned HSLOT_W      = 12;
  localparam int unsigned LAYER_W      = 5;
  localparam int unsigned OFFSET_W     = 17;
  localparam int unsigned DRONE_W      = 8;
  localparam int unsigned APB_DATA_W   = 32;
  localparam int unsigned APB_ADDR_W   = 2;
  localparam logic [HSLOT_W-1:0] H_SLOT_RESET = 12'd1000;
  localparam logic [OFFSET_W-1:0] OFFSET_LIMIT = 17'd65520;

  localparam logic OP_ASSIGN = 1'b0;
  localparam logic OP_CLEAR  = 1'b1;

endpackage

### rtl/core/greedy_layer_assigner_top.sv
// Channel   | Direction | Signals                           | Handshake
// ----------+-----------+-----------------------------------+---------------------------------
// command   | in        | op, drone_a, drone_b              | taken when start and not busy
// result    | out       | layer, offset_mm, overflow        | done high for one cycle, no stall
// config    | in/out    | psel, penable, pwrite, paddr, ... | APB read/write, pready always high
//
// For an assign item the masks of both drones are read from the store when the item is
// taken, the layer is found and the first drone's mask written in the next cycle, and the
// second drone's mask is written while the following item is read, so a new item can be
// taken while the second mask of the last one is still being written. The result is
// registered from that write stage. The single write port of the mask store keeps the two
// mask writes apart. A clear item holds busy high while the store is swept one entry per
// cycle; after reset the same sweep runs. The receiver cannot stall results.
module greedy_layer_assigner_top #(
  parameter int unsigned NUM_DRONES = 256,
  parameter int unsigned MAX_LAYERS = 32
) (
  input  logic                                    clk,
  input  logic                                    rst,
  input  logic                                    start,
  output logic                                    busy,
  input  logic                                    op,
  input  logic [gla_pkg::DRONE_W-1:0]             drone_a,
  input  logic [gla_pkg::DRONE_W-1:0]             drone_b,
  output logic                                    done,
  output logic [gla_pkg::LAYER_W-1:0]             layer,
  output logic signed [gla_pkg::OFFSET_W-1:0]     offset_mm,
  output logic                                    overflow,
  input  logic                                    psel,
  input  logic                                    penable,
  input  logic                                    pwrite,
  input  logic [gla_pkg::APB_ADDR_W-1:0]          paddr,
  input  logic [gla_pkg::APB_DATA_W-1:0]          pwdata,
  output logic [gla_pkg::APB_DATA_W-1:0]          prdata,
  output logic                                    pready
);

  localparam int unsigned AW = (NUM_DRONES > 1) ? $clog2(NUM_DRONES) : 1;
  localparam int unsigned IW = (AW > gla_pkg::DRONE_W) ? AW : gla_pkg::DRONE_W;
  localparam int unsigned LW = $clog2(MAX_LAYERS);
  localparam int unsigned PW = (LW + gla_pkg::HSLOT_W > gla_pkg::OFFSET_W) ?
                               LW + gla_pkg::HSLOT_W : gla_pkg::OFFSET_W;

  gla_pkg::state_t state, state_next;

  logic [gla_pkg::HSLOT_W-1:0] h_slot;

  logic [MAX_LAYERS-1:0] mem [NUM_DRONES];
  logic [MAX_LAYERS-1:0] rd_a, rd_b;

  logic [AW-1:0] a_q, b_q, clr_cnt;
  logic          in_range_q;

  logic [AW-1:0]         fwd_addr;
  logic [MAX_LAYERS-1:0] fwd_data;
  logic                  fwd_valid;

  logic [LW-1:0]         lay_q;
  logic                  ok_q;
  logic [MAX_LAYERS-1:0] b_new_q;

  logic                  accept;
  logic [IW-1:0]         a_wide, b_wide;
  logic                  a_in, b_in;
  logic [MAX_LAYERS-1:0] rd_a_eff, rd_b_eff, used_mask, pick_bit;
  logic [LW-1:0]         pick;
  logic                  found, calc_ok;

  logic                  wr_en;
  logic [AW-1:0]         wr_addr;
  logic [MAX_LAYERS-1:0] wr_data;

  logic [LW:0]           lay_inc;
  logic [LW-1:0]         mag;
  logic [PW-1:0]         prod;
  logic [gla_pkg::OFFSET_W-1:0] sat;

  assign busy   = (state == gla_pkg::S_CALC) || (state == gla_pkg::S_CLEAR);
  assign accept = start && !busy;
  assign pready = 1'b1;
  assign prdata = gla_pkg::APB_DATA_W'(h_slot);

  assign a_wide = IW'(drone_a);
  assign b_wide = IW'(drone_b);
  assign a_in   = {1'b0, a_wide} < (IW + 1)'(NUM_DRONES);
  assign b_in   = {1'b0, b_wide} < (IW + 1)'(NUM_DRONES);

  // The only register fills the whole address span.
  always_ff @(posedge clk) begin
    if (rst) begin
      h_slot <= gla_pkg::H_SLOT_RESET;
    end else if (psel && penable && pwrite && pready) begin
      h_slot <= pwdata[gla_pkg::HSLOT_W-1:0];
    end
  end

  always_comb begin
    state_next = state;
    unique case (state)
      gla_pkg::S_IDLE, gla_pkg::S_WRB: begin
        if (accept) begin
          state_next = (op == gla_pkg::OP_CLEAR) ? gla_pkg::S_CLEAR : gla_pkg::S_CALC;
        end else begin
          state_next = gla_pkg::S_IDLE;
        end
      end
      gla_pkg::S_CALC: state_next = gla_pkg::S_WRB;
      gla_pkg::S_CLEAR: begin
        if (clr_cnt == AW'(NUM_DRONES - 1)) begin
          state_next = gla_pkg::S_IDLE;
        end
      end
      default: state_next = gla_pkg::S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state   <= gla_pkg::S_CLEAR;
      clr_cnt <= '0;
    end else begin
      state <= state_next;
      if (accept) begin
        clr_cnt <= '0;
      end else if (state == gla_pkg::S_CLEAR) begin
        clr_cnt <= clr_cnt + AW'(1);
      end
    end
  end

  // The second drone's mask is written at the same edge as the next item reads the
  // store, so that write is carried over to the next calculation cycle.
  assign rd_a_eff = (fwd_valid && fwd_addr == a_q) ? fwd_data : rd_a;
  assign rd_b_eff = (fwd_valid && fwd_addr == b_q) ? fwd_data : rd_b;
  assign used_mask = rd_a_eff | rd_b_eff;

  always_comb begin
    found = 1'b0;
    pick  = '0;
    for (int k = MAX_LAYERS - 1; k >= 0; k--) begin
      if (!used_mask[k]) begin
        found = 1'b1;
        pick  = LW'(k);
      end
    end
  end

  assign pick_bit = MAX_LAYERS'(1) << pick;
  assign calc_ok  = in_range_q && found;

  always_comb begin
    wr_en   = 1'b0;
    wr_addr = a_q;
    wr_data = rd_a_eff | pick_bit;
    unique case (state)
      gla_pkg::S_CALC: begin
        wr_en = calc_ok;
      end
      gla_pkg::S_WRB: begin
        wr_en   = ok_q;
        wr_addr = b_q;
        wr_data = b_new_q;
      end
      gla_pkg::S_CLEAR: begin
        wr_en   = 1'b1;
        wr_addr = clr_cnt;
        wr_data = '0;
      end
      default: wr_en = 1'b0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (accept) begin
      rd_a <= mem[a_wide[AW-1:0]];
      rd_b <= mem[b_wide[AW-1:0]];
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      a_q        <= a_wide[AW-1:0];
      b_q        <= b_wide[AW-1:0];
      in_range_q <= a_in && b_in;
    end
    if (state == gla_pkg::S_CALC) begin
      lay_q   <= pick;
      ok_q    <= calc_ok;
      b_new_q <= rd_b_eff | pick_bit;
    end
    fwd_addr <= b_q;
    fwd_data <= b_new_q;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      fwd_valid <= 1'b0;
    end else begin
      fwd_valid <= (state == gla_pkg::S_WRB) && ok_q;
    end
  end

  // Odd layers go up, even layers go down, by ceil(layer / 2) steps.
  assign lay_inc = (LW + 1)'(lay_q) + (LW + 1)'(1);
  assign mag     = lay_inc[LW:1];
  assign prod    = PW'(mag) * PW'(h_slot);
  assign sat     = (prod > PW'(gla_pkg::OFFSET_LIMIT)) ? gla_pkg::OFFSET_LIMIT :
                   prod[gla_pkg::OFFSET_W-1:0];

  always_ff @(posedge clk) begin
    if (rst) begin
      done <= 1'b0;
    end else begin
      done <= (state == gla_pkg::S_WRB);
    end
  end

  always_ff @(posedge clk) begin
    if (state == gla_pkg::S_WRB) begin
      if (ok_q) begin
        layer     <= 6'(lay_q) > 6'd0 ? gla_pkg::LAYER_W'(6'(lay_q)) : '0;
        offset_mm <= lay_q[0] ? sat : (gla_pkg::OFFSET_W'(0) - sat);
        overflow  <= 1'b0;
      end else begin
        layer     <= '0;
        offset_mm <= '0;
        overflow  <= 1'b1;
      end
    end
  end

  a_result_from_write_stage: assert property (@(posedge clk) disable iff (rst)
    done |-> $past(state == gla_pkg::S_WRB))
    else $error("result strobe without a preceding write stage");

  a_overflow_zero: assert property (@(posedge clk) disable iff (rst)
    done && overflow |-> layer == '0 && offset_mm == '0)
    else $error("overflow result carries a non-zero layer or offset");

  a_calc_after_accept: assert property (@(posedge clk) disable iff (rst)
    state == gla_pkg::S_CALC |-> $past(start && !busy))
    else $error("calculation cycle without an accepted item");

  a_forward_source: assert property (@(posedge clk) disable iff (rst)
    fwd_valid |-> $past(state == gla_pkg::S_WRB && ok_q))
    else $error("forwarded mask without a second-drone write");

endmodule

### verif/greedy_layer_assigner_top_tb.sv
module greedy_layer_assigner_top_tb;

  localparam int unsigned NUM_DRONES = 256;
  localparam int unsigned MAX_LAYERS = 32;
  localparam int unsigned CYCLE_LIMIT = 1_500_000;
  localparam int unsigned PHASE_ITEMS = 230;
  localparam logic [gla_pkg::APB_ADDR_W-1:0] ADDR_H_SLOT = '0;

  typedef struct packed {
    logic [gla_pkg::LAYER_W-1:0]         layer;
    logic signed [gla_pkg::OFFSET_W-1:0] offset;
    logic                                ovf;
  } grant_t;

  typedef struct packed {
    logic                                op;
    logic [gla_pkg::DRONE_W-1:0]         a;
    logic [gla_pkg::DRONE_W-1:0]         b;
    logic                                typed;
    logic [gla_pkg::LAYER_W-1:0]         layer;
    logic signed [gla_pkg::OFFSET_W-1:0] offset;
    logic                                ovf;
  } event_row_t;

  // Rows marked typed carry the grant worked out by hand with the reset step of 1000 mm.
  localparam event_row_t EVENT_ROWS [0:14] = '{
    '{gla_pkg::OP_ASSIGN, 8'h00, 8'h00, 1'b1, 5'd0, 17'sd0,     1'b0},
    '{gla_pkg::OP_ASSIGN, 8'h00, 8'hFF, 1'b1, 5'd1, 17'sd1000,  1'b0},
    '{gla_pkg::OP_ASSIGN, 8'hFF, 8'hFF, 1'b1, 5'd0, 17'sd0,     1'b0},
    '{gla_pkg::OP_ASSIGN, 8'h00, 8'hFF, 1'b1, 5'd2, -17'sd1000, 1'b0},
    '{gla_pkg::OP_ASSIGN, 8'hFF, 8'h00, 1'b1, 5'd3, 17'sd2000,  1'b0},
    '{gla_pkg::OP_ASSIGN, 8'h01, 8'h02, 1'b1, 5'd0, 17'sd0,     1'b0},
    '{gla_pkg::OP_ASSIGN, 8'hAA, 8'h55, 1'b0, 5'd0, 17'sd0,     1'b0},
    '{gla_pkg::OP_ASSIGN, 8'h55, 8'hAA, 1'b0, 5'd0, 17'sd0,     1'b0},
    '{gla_pkg::OP_ASSIGN, 8'h55, 8'h00, 1'b0, 5'd0, 17'sd0,     1'b0},
    '{gla_pkg::OP_CLEAR,  8'hFF, 8'hFF, 1'b0, 5'd0, 17'sd0,     1'b0},
    '{gla_pkg::OP_ASSIGN, 8'h00, 8'hFF, 1'b1, 5'd0, 17'sd0,     1'b0},
    '{gla_pkg::OP_ASSIGN, 8'h7F, 8'h80, 1'b0, 5'd0, 17'sd0,     1'b0},
    '{gla_pkg::OP_ASSIGN, 8'h80, 8'h80, 1'b0, 5'd0, 17'sd0,     1'b0},
    '{gla_pkg::OP_CLEAR,  8'h00, 8'h00, 1'b0, 5'd0, 17'sd0,     1'b0},
    '{gla_pkg::OP_ASSIGN, 8'hFE, 8'h01, 1'b1, 5'd0, 17'sd0,     1'b0}
  };

  logic                                clk = 1'b0;
  logic                                rst = 1'b1;
  logic                                start = 1'b0;
  logic                                busy;
  logic                                op = gla_pkg::OP_ASSIGN;
  logic [gla_pkg::DRONE_W-1:0]         drone_a = '0;
  logic [gla_pkg::DRONE_W-1:0]         drone_b = '0;
  logic                                done;
  logic [gla_pkg::LAYER_W-1:0]         layer;
  logic signed [gla_pkg::OFFSET_W-1:0] offset_mm;
  logic                                overflow;
  logic                                psel = 1'b0;
  logic                                penable = 1'b0;
  logic                                pwrite = 1'b0;
  logic [gla_pkg::APB_ADDR_W-1:0]      paddr = '0;
  logic [gla_pkg::APB_DATA_W-1:0]      pwdata = '0;
  logic [gla_pkg::APB_DATA_W-1:0]      prdata;
  logic                                pready;

  // Predictor state: one layer mask per drone and the altitude step.
  logic [MAX_LAYERS-1:0]        drone_layers [0:NUM_DRONES-1];
  logic [gla_pkg::HSLOT_W-1:0]  h_step;

  grant_t      grants_due [$];
  int unsigned mismatches = 0;
  int unsigned items_sent = 0;
  int unsigned cycles = 0;

  greedy_layer_assigner_top #(
    .NUM_DRONES(NUM_DRONES),
    .MAX_LAYERS(MAX_LAYERS)
  ) u_top (
    .clk      (clk),
    .rst      (rst),
    .start    (start),
    .busy     (busy),
    .op       (op),
    .drone_a  (drone_a),
    .drone_b  (drone_b),
    .done     (done),
    .layer    (layer),
    .offset_mm(offset_mm),
    .overflow (overflow),
    .psel     (psel),
    .penable  (penable),
    .pwrite   (pwrite),
    .paddr    (paddr),
    .pwdata   (pwdata),
    .prdata   (prdata),
    .pready   (pready)
  );

  always #5 clk = ~clk;

  always @(posedge clk) begin
    cycles++;
    if (cycles > CYCLE_LIMIT) begin
      $display("[greedy_layer_assigner_top] ERROR");
      $finish;
    end
  end

  task automatic flag(input string what);
    $display("mismatch at cycle %0d: %s", cycles, what);
    mismatches++;
  endtask

  // Smallest layer free at both drones; the layer is then marked at both.
  task automatic predict_grant(input logic [gla_pkg::DRONE_W-1:0] a,
                               input logic [gla_pkg::DRONE_W-1:0] b,
                               output grant_t g);
    logic [MAX_LAYERS-1:0]        taken;
    int unsigned                  mag;
    int unsigned                  mm;
    logic [gla_pkg::OFFSET_W-1:0] mm17;
    int                           k;
    logic                         found;
    taken = drone_layers[a] | drone_layers[b];
    found = 1'b0;
    g = '{layer: '0, offset: '0, ovf: 1'b1};
    for (k = 0; k < MAX_LAYERS; k++) begin
      if (!found && !taken[k]) begin
        found = 1'b1;
        drone_layers[a][k] = 1'b1;
        drone_layers[b][k] = 1'b1;
        mag = (k + 1) / 2;
        mm = mag * h_step;
        if (mm > gla_pkg::OFFSET_LIMIT) begin
          mm = 32'(gla_pkg::OFFSET_LIMIT);
        end
        mm17 = mm[gla_pkg::OFFSET_W-1:0];
        g.layer = k[gla_pkg::LAYER_W-1:0];
        g.offset = k[0] ? mm17 : -mm17;
        g.ovf = 1'b0;
      end
    end
  endtask

  task automatic issue(input logic op_v, input logic [gla_pkg::DRONE_W-1:0] a,
                       input logic [gla_pkg::DRONE_W-1:0] b, input logic typed,
                       input grant_t typed_grant, input int gap);
    grant_t g;
    int     d;
    start <= 1'b1;
    op <= op_v;
    drone_a <= a;
    drone_b <= b;
    do @(posedge clk); while (busy);
    items_sent++;
    if (op_v == gla_pkg::OP_ASSIGN) begin
      predict_grant(a, b, g);
      grants_due = {grants_due, (typed ? typed_grant : g)};
    end else begin
      for (d = 0; d < NUM_DRONES; d++) begin
        drone_layers[d] = '0;
      end
    end
    if (gap > 0) begin
      start <= 1'b0;
      repeat (gap) @(posedge clk);
    end
  endtask

  task automatic issue_random(input logic op_v, input logic [gla_pkg::DRONE_W-1:0] a,
                              input logic [gla_pkg::DRONE_W-1:0] b, input logic steady);
    issue(op_v, a, b, 1'b0, '0, steady ? 0 : $urandom_range(0, 5));
  endtask

  // Hold the sender off until every outstanding grant has come back.
  task automatic drain();
    start <= 1'b0;
    @(posedge clk);
    while (grants_due.size() != 0) @(posedge clk);
  endtask

  // A clear item gives no grant, so the sweep is waited out through busy.
  task automatic settle();
    drain();
    while (busy) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic apb_write(input logic [gla_pkg::APB_DATA_W-1:0] data);
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b1;
    paddr <= ADDR_H_SLOT;
    pwdata <= data;
    @(posedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    h_step = data[gla_pkg::HSLOT_W-1:0];
    psel <= 1'b0;
    penable <= 1'b0;
    pwrite <= 1'b0;
    @(posedge clk);
  endtask

  task automatic apb_check();
    logic [gla_pkg::APB_DATA_W-1:0] seen;
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b0;
    paddr <= ADDR_H_SLOT;
    @(posedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    seen = prdata;
    if (seen !== gla_pkg::APB_DATA_W'(h_step)) begin
      flag($sformatf("h_slot reads %0d, expected %0d", seen, h_step));
    end
    psel <= 1'b0;
    penable <= 1'b0;
    @(posedge clk);
  endtask

  // Half the segments hammer one hub drone until its masks run out, so the deep layers,
  // the largest offsets and overflow all occur; the rest are clusters, noise and drains.
  task automatic run_random(input int unsigned count);
    int unsigned                 goal;
    int unsigned                 kind;
    int unsigned                 len;
    int unsigned                 width;
    int unsigned                 i;
    logic                        steady;
    logic [gla_pkg::DRONE_W-1:0] hub;
    logic [gla_pkg::DRONE_W-1:0] base;
    logic [gla_pkg::DRONE_W-1:0] partner;
    goal = items_sent + count;
    while (items_sent < goal) begin
      kind = $urandom_range(0, 9);
      steady = ($urandom_range(0, 3) == 0);
      hub = gla_pkg::DRONE_W'($urandom_range(0, NUM_DRONES - 1));
      base = gla_pkg::DRONE_W'($urandom_range(0, NUM_DRONES - 1));
      width = $urandom_range(1, 12);
      if (kind <= 4) begin
        if ($urandom_range(0, 3) != 0) begin
          issue_random(gla_pkg::OP_CLEAR, gla_pkg::DRONE_W'($urandom_range(0, 255)),
                       gla_pkg::DRONE_W'($urandom_range(0, 255)), steady);
        end
        len = $urandom_range(34, 60);
        for (i = 0; i < len; i++) begin
          if ($urandom_range(0, 7) == 0) begin
            partner = hub;
          end else begin
            partner = base + gla_pkg::DRONE_W'($urandom_range(0, width));
          end
          if ($urandom_range(0, 1) == 1) begin
            issue_random(gla_pkg::OP_ASSIGN, hub, partner, steady);
          end else begin
            issue_random(gla_pkg::OP_ASSIGN, partner, hub, steady);
          end
        end
      end else if (kind <= 7) begin
        len = $urandom_range(10, 40);
        for (i = 0; i < len; i++) begin
          issue_random(($urandom_range(0, 29) == 0) ? gla_pkg::OP_CLEAR : gla_pkg::OP_ASSIGN,
                       base + gla_pkg::DRONE_W'($urandom_range(0, width)),
                       base + gla_pkg::DRONE_W'($urandom_range(0, width)), steady);
        end
      end else if (kind == 8) begin
        len = $urandom_range(5, 15);
        for (i = 0; i < len; i++) begin
          issue_random(($urandom_range(0, 7) == 0) ? gla_pkg::OP_CLEAR : gla_pkg::OP_ASSIGN,
                       gla_pkg::DRONE_W'($urandom_range(0, 255)),
                       gla_pkg::DRONE_W'($urandom_range(0, 255)), steady);
        end
      end else begin
        drain();
      end
    end
  endtask

  always @(posedge clk) begin
    grant_t want;
    if (!rst && done) begin
      if (grants_due.size() == 0) begin
        flag($sformatf("grant with none outstanding: layer %0d offset %0d overflow %0b",
                       layer, offset_mm, overflow));
      end else begin
        want = grants_due.pop_front();
        if (layer !== want.layer) begin
          flag($sformatf("layer %0d, expected %0d", layer, want.layer));
        end
        if (offset_mm !== want.offset) begin
          flag($sformatf("offset_mm %0d, expected %0d", offset_mm, want.offset));
        end
        if (overflow !== want.ovf) begin
          flag($sformatf("overflow %0b, expected %0b", overflow, want.ovf));
        end
      end
    end
  end

  initial begin
    logic [gla_pkg::APB_DATA_W-1:0] h_plan [0:6];
    int                             d;
    int                             r;
    int                             p;
    for (d = 0; d < NUM_DRONES; d++) begin
      drone_layers[d] = '0;
    end
    h_step = gla_pkg::H_SLOT_RESET;
    h_plan[0] = 32'd4095;
    h_plan[1] = 32'd0;
    // Bits above the register width must be dropped.
    h_plan[2] = 32'h5A5A_FABC;
    h_plan[3] = 32'd1;
    h_plan[4] = $urandom_range(0, 4095);
    h_plan[5] = $urandom;
    h_plan[6] = 32'd4095;

    repeat (8) @(posedge clk);
    rst <= 1'b0;
    settle();
    apb_check();

    for (r = 0; r < 15; r++) begin
      issue(EVENT_ROWS[r].op, EVENT_ROWS[r].a, EVENT_ROWS[r].b, EVENT_ROWS[r].typed,
            '{EVENT_ROWS[r].layer, EVENT_ROWS[r].offset, EVENT_ROWS[r].ovf},
            $urandom_range(0, 5));
    end

    for (p = 0; p < 7; p++) begin
      settle();
      apb_write(h_plan[p]);
      apb_check();
      run_random(PHASE_ITEMS);
    end

    settle();
    repeat (6) @(posedge clk);
    if (mismatches == 0 && grants_due.size() == 0) begin
      $display("[greedy_layer_assigner_top] OK");
    end else begin
      $display("[greedy_layer_assigner_top] ERROR");
    end
    $finish;
  end

endmodule

### sim.f
rtl/core/gla_pkg.sv
rtl/core/greedy_layer_assigner_top.sv
verif/greedy_layer_assigner_top_tb.sv
